// File: rtl/dvru_pkg.sv
// Shared types and constants for the distance-vector route update engine.
// No dependencies; every other file of the block imports this package.
package dvru_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NBR_COUNT   = 256;
  localparam logic [7:0]  INF_RESET   = 8'd16;

  typedef enum logic [1:0] {
    KIND_ADVERT  = 2'd0,
    KIND_INSTALL = 2'd1,
    KIND_MARK    = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ACT_IGNORED   = 3'd0,
    ACT_ADDED     = 3'd1,
    ACT_REFRESHED = 3'd2,
    ACT_REPLACED  = 3'd3,
    ACT_DROPPED   = 3'd4,
    ACT_FULL      = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    OP_ADVERT,
    OP_INSTALL,
    OP_DROP,
    OP_MARK,
    OP_IGNORE
  } op_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] neighbor_id;
    logic [7:0] destination;
    logic [7:0] distance;
    logic [7:0] link_cost;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] update_count;
  } result_t;

  // Classified command handed from the front end to the table engine.
  typedef struct packed {
    op_e        op;
    logic [7:0] nb;
    logic [7:0] dst;
    logic [7:0] metric;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// File: rtl/dvru_front.sv
// Front end: holds the infinity register, accepts items and classifies them.
// Depends on dvru_pkg.
module dvru_front
  import dvru_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       start_i,
  input  item_t      item_i,
  input  q_stat_t    q_stat_i,
  output logic       busy_o,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [7:0] inf_q;
  logic [8:0] sum;
  logic [7:0] sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inf_q <= INF_RESET;
    end else if (cfg_we_i) begin
      inf_q <= cfg_wdata_i;
    end
  end

  // The advertised distance plus link cost, clamped at infinity.
  assign sum = {1'b0, item_i.distance} + {1'b0, item_i.link_cost};
  assign sat = (sum > {1'b0, inf_q}) ? inf_q : sum[7:0];

  always_comb begin
    cmd_o.nb     = item_i.neighbor_id;
    cmd_o.dst    = item_i.destination;
    cmd_o.metric = item_i.distance;
    case (kind_e'(item_i.kind))
      KIND_ADVERT: begin
        cmd_o.metric = sat;
        if (sat == inf_q && item_i.destination == item_i.neighbor_id) begin
          cmd_o.op = OP_DROP;
        end else begin
          cmd_o.op = OP_ADVERT;
        end
      end
      KIND_INSTALL: cmd_o.op = OP_INSTALL;
      KIND_MARK:    cmd_o.op = OP_MARK;
      default:      cmd_o.op = OP_IGNORE;
    endcase
  end

  assign busy_o = q_stat_i.full;
  assign push_o = start_i && !q_stat_i.full;

endmodule

// File: rtl/dvru_queue.sv
// Small command queue between the front end and the table engine.
// Depends on dvru_pkg.
module dvru_queue
  import dvru_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t q_stat_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign q_stat_o.empty = (cnt_q == '0);
  assign q_stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push        = push_i && !q_stat_o.full;
  assign do_pop         = pop_i && !q_stat_o.empty;
  assign cmd_o          = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/dvru_back.sv
// Table engine: scans the route table one entry per cycle, applies the update,
// keeps the adjacency map and the change counter, and drives the result.
// Depends on dvru_pkg.
module dvru_back
  import dvru_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t q_stat_i,
  input  cmd_t    cmd_i,
  output logic    pop_o,
  output logic    result_valid_o,
  output result_t result_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  state_e               state_q;
  cmd_t                 cmd_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic [7:0]           hit_dist_q;
  logic [7:0]           hit_hop_q;
  logic                 free_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [15:0]          cnt_q;
  logic [15:0]          cnt_d;
  logic [NBR_COUNT-1:0] nbr_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                 res_valid_q;
  result_t              res_q;

  logic [7:0] rt_dst_q  [TABLE_DEPTH];
  logic [7:0] rt_dist_q [TABLE_DEPTH];
  logic [7:0] rt_hop_q  [TABLE_DEPTH];

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  action_e          act;
  logic             inc;

  assign pop_o          = (state_q == S_IDLE) && !q_stat_i.empty;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Decision once the scan has found the first match and the lowest free entry.
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = hit_idx_q;
    act    = ACT_IGNORED;
    inc    = 1'b0;
    if (cmd_q.op == OP_ADVERT) begin
      if (!hit_q) begin
        if (free_q) begin
          wr_en  = 1'b1;
          wr_idx = free_idx_q;
          act    = ACT_ADDED;
          inc    = 1'b1;
        end else begin
          act = ACT_FULL;
        end
      end else if (hit_hop_q == cmd_q.nb) begin
        if (hit_dist_q != cmd_q.metric) begin
          wr_en = 1'b1;
          act   = ACT_REFRESHED;
          inc   = 1'b1;
        end
      end else if (hit_dist_q > cmd_q.metric) begin
        wr_en = 1'b1;
        act   = ACT_REPLACED;
        inc   = 1'b1;
      end
    end else begin
      if (hit_q) begin
        wr_en = 1'b1;
        act   = ACT_REFRESHED;
      end else if (free_q) begin
        wr_en  = 1'b1;
        wr_idx = free_idx_q;
        act    = ACT_ADDED;
      end else begin
        act = ACT_FULL;
      end
    end
    cnt_d = cnt_q + {15'd0, inc};
  end

  // An advertised refresh keeps destination and hop, so a whole-entry write suffices.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DECIDE && wr_en) begin
      rt_dst_q[wr_idx]  <= cmd_q.dst;
      rt_dist_q[wr_idx] <= cmd_q.metric;
      rt_hop_q[wr_idx]  <= cmd_q.nb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_dist_q  <= '0;
      hit_hop_q   <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      cnt_q       <= '0;
      nbr_q       <= '0;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!q_stat_i.empty) begin
            cmd_q <= cmd_i;
            case (cmd_i.op)
              OP_ADVERT, OP_INSTALL: begin
                state_q <= S_SCAN;
                idx_q   <= '0;
                hit_q   <= 1'b0;
                free_q  <= 1'b0;
              end
              OP_DROP: begin
                nbr_q[cmd_i.nb] <= 1'b0;
                res_valid_q     <= 1'b1;
                res_q           <= '{action: ACT_DROPPED, update_count: cnt_q};
              end
              OP_MARK: begin
                nbr_q[cmd_i.nb] <= 1'b1;
                res_valid_q     <= 1'b1;
                res_q           <= '{action: ACT_IGNORED, update_count: cnt_q};
              end
              default: begin
                res_valid_q <= 1'b1;
                res_q       <= '{action: ACT_IGNORED, update_count: cnt_q};
              end
            endcase
          end
        end
        S_SCAN: begin
          if (valid_q[idx_q] && rt_dst_q[idx_q] == cmd_q.dst && !hit_q) begin
            hit_q      <= 1'b1;
            hit_idx_q  <= idx_q;
            hit_dist_q <= rt_dist_q[idx_q];
            hit_hop_q  <= rt_hop_q[idx_q];
          end
          if (!valid_q[idx_q] && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= idx_q;
          end
          if (idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
            state_q <= S_DECIDE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_DECIDE: begin
          if (wr_en) begin
            valid_q[wr_idx] <= 1'b1;
          end
          cnt_q       <= cnt_d;
          res_valid_q <= 1'b1;
          res_q       <= '{action: act, update_count: cnt_d};
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/distance_vector_route_update_core.sv
// Top level of the distance-vector route update engine.
// Depends on dvru_pkg, dvru_front, dvru_queue and dvru_back.
//
// Usage:
//   Items enter on item_i and are taken at a rising edge where start_i is high
//   and busy_o is low. busy_o rises only while the two-entry command queue is
//   full. Every item yields exactly one result on result_o, shown for a single
//   cycle with result_valid_o high; the receiver must take it in that cycle.
//   The user writes the infinity metric through cfg_we_i/cfg_wdata_i only while
//   idle; the block itself does not enforce this.
// Flow:
//   Neighbor drop, neighbor mark and unknown kinds give their result once the
//   engine takes them from the queue. Advertised and installed routes walk the
//   route table one entry per cycle, then a decide state writes the entry and
//   registers the result. The engine takes one command at a time; the queue
//   lets the next items be taken while a scan runs.
// Reset:
//   rst_ni clears the route valid bits, the adjacency map, the change counter
//   and the queue, and sets the infinity metric to 16. No clearing pass is run.
module distance_vector_route_update_core
  import dvru_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       start_i,
  input  item_t      item_i,
  output logic       busy_o,
  output logic       result_valid_o,
  output result_t    result_o
);

  q_stat_t q_stat;
  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    push;
  logic    pop;

  dvru_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .item_i      (item_i),
    .q_stat_i    (q_stat),
    .busy_o      (busy_o),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  dvru_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .q_stat_o (q_stat)
  );

  dvru_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // An accepted beat is visible in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> !q_stat.empty)
    else $error("accepted beat did not reach the command queue");

  // The result register only changes when a result is strobed.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |=> (result_valid_o || $stable(result_o)))
    else $error("result changed without a strobe");

  // A table change moves the count by at most one: advertised routes add one, installs none.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.action == ACT_ADDED || result_o.action == ACT_REFRESHED ||
                       result_o.action == ACT_REPLACED)
    |-> (result_o.update_count == $past(result_o.update_count) + 16'd1 ||
         result_o.update_count == $past(result_o.update_count)))
    else $error("update count moved by more than one");

  // Drops, full table and ignored items leave the count alone.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.action == ACT_DROPPED || result_o.action == ACT_FULL ||
                       result_o.action == ACT_IGNORED)
    |-> result_o.update_count == $past(result_o.update_count))
    else $error("update count moved without a table change");

endmodule
